// File: rtl/dhss_pkg.sv
// Package for the double hashing string set: constants, types, hash constants.
`timescale 1ns / 1ps
`default_nettype none
package dhss_pkg;
    localparam int MAX_KEY_CHARS_DEF = 8;
    localparam int INITIAL_SLOTS_DEF = 8;
    localparam int MAX_SLOTS_DEF     = 64;

    localparam int LETTERS_W = 40;
    localparam int LEN_W     = 4;
    localparam int OP_W      = 2;

    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;
    localparam logic [OP_W-1:0] OP_INVALID = 2'd3;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_KEY   = 2'd1,
        ST_TOMB  = 2'd2
    } t_status;

    localparam logic [7:0] ASCII_A = 8'd97;
    localparam logic [31:0] MUL_H1 = 32'd11;
    localparam logic [31:0] MUL_H2 = 32'd13;
endpackage
`default_nettype wire

// File: rtl/double_hashing_string_set_top.sv
// Top level of the double hashing string set: sequencer, table memory, shared hash/probe unit.
//  channel | dir | signals                                       | accept
//  request | in  | i_valid o_ready i_operation i_key_letters      | i_valid & o_ready
//          |     | i_key_length                                  |
//  result  | out | o_valid i_ready o_ok                          | o_valid & i_ready
// Hash steps through the key one letter at a time; each probe is a memory read, then a check.
// Query/delete: hash, then probe. Add may first grow the table, which walks every old slot,
// rehashes each key and probes the new size.
// Reset: synchronous, active low; then a clearing pass over all MAX_SLOTS status memory
// entries while o_ready is low. The result register holds o_ok until taken; the next
// request is taken only after the result leaves.
`timescale 1ns / 1ps
`default_nettype none
module double_hashing_string_set_top #(
    parameter int MAX_KEY_CHARS = dhss_pkg::MAX_KEY_CHARS_DEF,
    parameter int INITIAL_SLOTS = dhss_pkg::INITIAL_SLOTS_DEF,
    parameter int MAX_SLOTS     = dhss_pkg::MAX_SLOTS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [dhss_pkg::OP_W-1:0]      i_operation,
    input  wire  [dhss_pkg::LETTERS_W-1:0] i_key_letters,
    input  wire  [dhss_pkg::LEN_W-1:0]     i_key_length,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic                         o_ok
);
    import dhss_pkg::*;

    localparam int BASE    = (INITIAL_SLOTS < MAX_SLOTS) ? INITIAL_SLOTS : MAX_SLOTS;
    localparam int AW      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int BASE_LG = $clog2(BASE);
    localparam int SL_MAX  = $clog2(MAX_SLOTS) - BASE_LG;
    localparam int SLW     = (SL_MAX > 0) ? $clog2(SL_MAX + 1) : 1;
    localparam int CW      = AW + 1;
    localparam int KCW     = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS + 1) : 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_GCHK, S_GCOPY, S_GSCAN, S_GRD,
        S_HASH, S_PRD, S_PCHK, S_DONE
    } t_state;

    // main and scratch memories
    logic [LETTERS_W-1:0] m_let [MAX_SLOTS];
    logic [LEN_W-1:0]     m_len [MAX_SLOTS];
    logic [1:0]           m_st  [MAX_SLOTS];
    logic [LETTERS_W-1:0] x_let [MAX_SLOTS];
    logic [LEN_W-1:0]     x_len [MAX_SLOTS];
    logic [1:0]           x_st  [MAX_SLOTS];

    t_state r_state, n_state;
    logic [SLW-1:0] r_size_log, n_size_log;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_placed, n_placed;
    logic [OP_W-1:0] r_op, n_op;
    logic [LETTERS_W-1:0] r_let, n_let;
    logic [LEN_W-1:0] r_len, n_len;
    logic [KCW-1:0] r_k, n_k;
    logic [31:0] r_h1, n_h1, r_h2, n_h2;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_scan, n_scan;
    logic [AW-1:0] r_slot, n_slot;
    logic r_have_tomb, n_have_tomb;
    logic [AW-1:0] r_tomb, n_tomb;
    logic r_regrow, n_regrow;
    logic r_ok, n_ok;
    logic r_oval, n_oval;

    // the add key is kept aside while the grow pass reuses r_let/r_len
    logic [LETTERS_W-1:0] r_key_let;
    logic [LEN_W-1:0] r_key_len;
    logic [LETTERS_W-1:0] x_let_hold;

    // memory read data (registered)
    logic [LETTERS_W-1:0] r_rd_let, r_xd_let;
    logic [LEN_W-1:0] r_rd_len, r_xd_len;
    logic [1:0] r_rd_st, r_xd_st;

    // memory control
    logic m_we_st, m_we_key;
    logic [AW-1:0] m_wa;
    logic [1:0] m_wst;
    logic [AW-1:0] m_ra, x_ra;
    logic x_we;
    logic [AW-1:0] x_wa;

    logic [CW-1:0] size;
    logic [AW-1:0] size_mask;
    logic [31:0] pos;
    logic [LEN_W-1:0] len_sat;
    logic [LETTERS_W-1:0] let_mask;
    logic [7:0] ch;
    logic [5:0] shamt;

    assign size = CW'(BASE) << r_size_log;
    assign size_mask = AW'(size - CW'(1));
    assign pos = r_h1 + r_i * r_h2;
    assign x_let_hold = r_key_let;

    always_comb begin
        len_sat = (i_key_length > LEN_W'(MAX_KEY_CHARS)) ? LEN_W'(MAX_KEY_CHARS) : i_key_length;
        let_mask = ~({LETTERS_W{1'b1}} << (5 * len_sat));
        shamt = 6'(5 * (r_len - LEN_W'(1) - LEN_W'(r_k)));
        ch = ASCII_A + 8'((r_let >> shamt) & LETTERS_W'(31));
    end

    always_ff @(posedge i_clk) begin
        if (m_we_st) m_st[m_wa] <= m_wst;
        if (m_we_key) begin
            m_let[m_wa] <= r_let;
            m_len[m_wa] <= r_len;
        end
        if (x_we) begin
            x_let[x_wa] <= r_rd_let;
            x_len[x_wa] <= r_rd_len;
            x_st[x_wa]  <= r_rd_st;
        end
        r_rd_let <= m_let[m_ra];
        r_rd_len <= m_len[m_ra];
        r_rd_st  <= m_st[m_ra];
        r_xd_let <= x_let[x_ra];
        r_xd_len <= x_len[x_ra];
        r_xd_st  <= x_st[x_ra];
    end

    always_comb begin
        n_state = r_state; n_size_log = r_size_log; n_count = r_count; n_placed = r_placed;
        n_op = r_op; n_let = r_let; n_len = r_len; n_k = r_k; n_h1 = r_h1; n_h2 = r_h2;
        n_i = r_i; n_scan = r_scan; n_slot = r_slot; n_have_tomb = r_have_tomb;
        n_tomb = r_tomb; n_regrow = r_regrow; n_ok = r_ok; n_oval = r_oval;
        m_we_st = 1'b0; m_we_key = 1'b0; m_wa = r_slot; m_wst = ST_EMPTY;
        m_ra = r_slot; x_ra = r_scan[AW-1:0]; x_we = 1'b0; x_wa = r_scan[AW-1:0];
        o_ready = 1'b0;
        if (r_oval && i_ready) n_oval = 1'b0;
        case (r_state)
            S_CLEAR: begin
                m_we_st = 1'b1; m_wa = r_scan[AW-1:0]; m_wst = ST_EMPTY;
                n_scan = r_scan + CW'(1);
                if (r_scan == CW'(MAX_SLOTS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = !r_oval;
                if (i_valid && !r_oval) begin
                    n_op = i_operation; n_len = len_sat; n_let = i_key_letters & let_mask;
                    n_k = '0; n_h1 = '0; n_h2 = '0; n_i = '0; n_have_tomb = 1'b0;
                    n_regrow = 1'b0;
                    if (len_sat == '0 || i_operation == OP_INVALID) begin
                        n_ok = 1'b0; n_oval = 1'b1;
                    end else if (i_operation == OP_ADD) n_state = S_GCHK;
                    else n_state = S_HASH;
                end
            end
            S_GCHK: begin
                if ((r_count << 2) >= 3 * size && (size << 1) <= CW'(MAX_SLOTS)
                        && size < CW'(MAX_SLOTS)) begin
                    n_scan = '0; n_state = S_GCOPY; m_ra = '0;
                end else n_state = S_HASH;
            end
            S_GCOPY: begin
                // r_rd_* holds slot r_scan-1 from the previous read
                m_ra = AW'(r_scan);
                if (r_scan != '0) begin
                    x_we = 1'b1; x_wa = AW'(r_scan - CW'(1));
                end
                m_we_st = (r_scan != '0);
                m_wa = AW'(r_scan - CW'(1)); m_wst = ST_EMPTY;
                n_scan = r_scan + CW'(1);
                if (r_scan == size) begin
                    n_size_log = r_size_log + SLW'(1);
                    n_scan = '0; n_placed = '0; n_state = S_GSCAN;
                end
            end
            S_GSCAN: begin
                x_ra = r_scan[AW-1:0];
                if (r_scan == (size >> 1)) begin
                    n_count = r_placed;
                    n_let = x_let_hold; n_k = '0; n_h1 = '0; n_h2 = '0;
                    n_state = S_HASH;
                end else n_state = S_GRD;
            end
            S_GRD: begin
                if (r_xd_st == ST_KEY) begin
                    n_let = r_xd_let; n_len = r_xd_len; n_k = '0; n_h1 = '0; n_h2 = '0;
                    n_i = '0; n_regrow = 1'b1; n_state = S_HASH;
                end else begin
                    n_scan = r_scan + CW'(1); n_state = S_GSCAN;
                end
            end
            S_HASH: begin
                if (KCW'(r_k) == KCW'(r_len)) begin
                    n_h2 = (r_h2 << 1) | 32'd1; n_state = S_PRD;
                end else begin
                    n_h1 = r_h1 * MUL_H1 + 32'(ch);
                    n_h2 = r_h2 * MUL_H2 + 32'(ch);
                    n_k = r_k + KCW'(1);
                end
            end
            S_PRD: begin
                if (r_i == size) begin
                    if (!r_regrow && r_op == OP_ADD && r_have_tomb) begin
                        m_we_st = 1'b1; m_we_key = 1'b1; m_wa = r_tomb; m_wst = ST_KEY;
                        n_count = r_count + CW'(1); n_ok = 1'b1;
                    end else n_ok = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_slot = AW'(pos) & size_mask; m_ra = AW'(pos) & size_mask;
                    n_state = S_PCHK;
                end
            end
            S_PCHK: begin
                n_i = r_i + CW'(1); n_state = S_PRD;
                if (r_regrow) begin
                    if (r_rd_st == ST_EMPTY) begin
                        m_we_st = 1'b1; m_we_key = 1'b1; m_wst = ST_KEY;
                        n_placed = r_placed + CW'(1); n_regrow = 1'b0;
                        n_scan = r_scan + CW'(1); n_state = S_GSCAN;
                    end
                end else if (r_rd_st == ST_EMPTY) begin
                    if (r_op == OP_ADD) begin
                        m_we_st = 1'b1; m_we_key = 1'b1; m_wst = ST_KEY;
                        m_wa = r_have_tomb ? r_tomb : r_slot;
                        n_count = r_count + CW'(1); n_ok = 1'b1;
                    end else n_ok = 1'b0;
                    n_state = S_DONE;
                end else if (r_rd_st == ST_KEY && r_rd_len == r_len && r_rd_let == r_let) begin
                    if (r_op == OP_DELETE) begin
                        m_we_st = 1'b1; m_wst = ST_TOMB; n_count = r_count - CW'(1);
                    end
                    n_ok = (r_op != OP_ADD); n_state = S_DONE;
                end else if (r_rd_st == ST_TOMB && !r_have_tomb) begin
                    n_have_tomb = 1'b1; n_tomb = r_slot;
                end
            end
            S_DONE: begin
                n_oval = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_key_let <= n_let;
            r_key_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_size_log <= '0; r_count <= '0; r_scan <= '0;
            r_oval <= 1'b0; r_ok <= 1'b0; r_regrow <= 1'b0;
        end else begin
            r_state <= n_state; r_size_log <= n_size_log; r_count <= n_count;
            r_scan <= n_scan; r_oval <= n_oval; r_ok <= n_ok; r_regrow <= n_regrow;
        end
        r_placed <= n_placed; r_op <= n_op; r_let <= n_let;
        r_len <= (r_state == S_GSCAN && n_state == S_HASH) ? r_key_len : n_len;
        r_k <= n_k; r_h1 <= n_h1; r_h2 <= n_h2;
        r_i <= (r_state == S_GSCAN && n_state == S_HASH) ? '0 : n_i;
        r_slot <= n_slot; r_have_tomb <= (r_state == S_GSCAN && n_state == S_HASH) ? 1'b0
                                         : n_have_tomb;
        r_tomb <= n_tomb;
    end

    assign o_valid = r_oval;
    assign o_ok    = r_ok;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= size) else $error("live count exceeds table size");
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        size <= CW'(MAX_SLOTS)) else $error("table size beyond max");
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && !i_ready) |=> (r_oval && $stable(r_ok))) else $error("result dropped");
endmodule
`default_nettype wire
